>>> rtl/linconv_pkg.sv
package linconv_pkg;

	// Width of one convolution result (signed Q6.30).
	localparam int RES_W = 37;
	// Result tdata is the result padded up to whole bytes.
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	// Field widths of the input word and of the configuration register.
	localparam int MODE_W = 2;
	localparam int IDX_W  = 5;
	localparam int CFG_W  = 6;

	// Input word kinds.
	localparam logic [MODE_W-1:0] MODE_LOAD_TAP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAMPLE   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH    = 2'd2;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic clr;	// clear the accumulator before a new sum
		logic en;	// a tap/sample pair is presented this cycle
	} mac_ctl_t;

endpackage

>>> rtl/linconv_mac.sv
// Shared multiply-accumulate unit: one registered product per cycle,
// then a wrapping add into the result-width accumulator.
module linconv_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  linconv_pkg::mac_ctl_t                 ctl,
	input  logic signed [SAMPLE_BITS-1:0]         tap,
	input  logic signed [SAMPLE_BITS-1:0]         smp,
	output logic signed [linconv_pkg::RES_W-1:0]  acc,
	output logic                                  busy
);

	logic signed [2*SAMPLE_BITS-1:0]        prod_s2;
	logic                                   v_s2;
	logic signed [linconv_pkg::RES_W-1:0]   acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= tap * smp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s2 <= ctl.en;
			if (ctl.clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				// Sign-extend or truncate the product to the result width;
				// the sum wraps at that width.
				acc_q <= acc_q + linconv_pkg::RES_W'(prod_s2);
			end
		end
	end

	assign acc  = acc_q;
	assign busy = v_s2;

endmodule

>>> rtl/linear_convolution_top.sv
// Streaming full linear convolution, built as a direct-form FIR filter.
// Input words arrive on the s_axis channel and carry a kind: a tap load writes
// one coefficient into the tap store, a sample shifts the delay line and
// yields one result, and a flush yields the tail results of a zero input, one
// fewer than the active taps, marks the last with tlast and empties the delay line.
// Results leave on the m_axis channel as full-precision Q6.30 words; every
// sample result carries tlast high as well.
// All sums are formed by one shared multiplier and accumulator that steps
// over the active taps one per cycle. The block takes no new input word
// until the sum for the current sample or tail result has been handed to
// the output register. Tap loads produce nothing.
// The result sits in an output register, so the block takes the next word
// while a result still waits; if the receiver stalls, the next finished sum
// waits inside the block and input stops until the output register frees.
// Reset empties the delay line at once through per-entry valid bits (no
// clearing pass is needed), sets tap_count to one and leaves the tap store
// undefined until it is written.
module linear_convolution_top #(
	parameter int MAX_TAPS    = 32,
	parameter int SAMPLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,

	// tdata fields from bit 0 up: mode[2], tap_index[5], value[SAMPLE_BITS],
	// then zero padding to whole bytes.
	input  logic                                                 s_axis_tvalid,
	output logic                                                 s_axis_tready,
	input  logic [((linconv_pkg::MODE_W + linconv_pkg::IDX_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0]
	                                                             s_axis_tdata,

	// tdata fields from bit 0 up: result_value[37], then zero padding.
	output logic                                                 m_axis_tvalid,
	input  logic                                                 m_axis_tready,
	output logic [linconv_pkg::OUT_TDATA_W-1:0]                  m_axis_tdata,
	output logic                                                 m_axis_tlast,

	// tap_count register write.
	input  logic                                                 cfg_wr_en,
	input  logic [linconv_pkg::CFG_W-1:0]                        cfg_wr_data
);

	localparam int PTR_W = $clog2(MAX_TAPS);
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int IDX_LSB = linconv_pkg::MODE_W;
	localparam int VAL_LSB = linconv_pkg::MODE_W + linconv_pkg::IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,	// waiting for an input word
		ST_STEP,	// advance the delay line by a zero for one tail result
		ST_RUN,		// sweep the active taps through the shared unit
		ST_FIN		// hand the finished sum to the output register
	} state_t;

	state_t state_q;

	// Input word fields.
	logic [linconv_pkg::MODE_W-1:0]   in_mode;
	logic [linconv_pkg::IDX_W-1:0]    in_idx;
	logic signed [SAMPLE_BITS-1:0]    in_val;
	logic                             in_acc;

	assign in_mode = s_axis_tdata[linconv_pkg::MODE_W-1:0];
	assign in_idx  = s_axis_tdata[IDX_LSB +: linconv_pkg::IDX_W];
	assign in_val  = s_axis_tdata[VAL_LSB +: SAMPLE_BITS];
	assign in_acc  = s_axis_tvalid && s_axis_tready;

	// Configuration register and the number of taps it selects, held within
	// one to MAX_TAPS.
	logic [linconv_pkg::CFG_W-1:0] tap_count_q;
	logic [CNT_W-1:0]              n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= linconv_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			tap_count_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (tap_count_q == '0) begin
			n_act = CNT_W'(1);
		end else if (int'(tap_count_q) > MAX_TAPS) begin
			n_act = CNT_W'(MAX_TAPS);
		end else begin
			n_act = CNT_W'(tap_count_q);
		end
	end

	// Sequencer registers.
	logic [PTR_W-1:0]              head_q;		// delay line entry of the newest sample
	logic [PTR_W-1:0]              rd_ptr_q;	// entry read in the current sweep step
	logic [MAX_TAPS-1:0]           dl_valid_q;	// entries not valid read as zero
	logic [CNT_W-1:0]              n_q;
	logic [CNT_W-1:0]              j_q;		// tap being issued
	logic [CNT_W-1:0]              k_q;		// tail result number
	logic                          tail_q;
	logic                          last_q;
	logic                          v_s1;
	logic                          out_valid_q;
	logic                          out_last_q;
	logic [linconv_pkg::RES_W-1:0] out_data_q;

	logic [PTR_W-1:0]              head_nx;
	logic [PTR_W-1:0]              rd_ptr_nx;
	logic                          issue;
	logic                          out_free;
	logic                          mac_busy;
	logic signed [linconv_pkg::RES_W-1:0] mac_acc;
	linconv_pkg::mac_ctl_t         mac_ctl;

	assign head_nx   = (head_q == PTR_W'(MAX_TAPS - 1)) ? '0 : head_q + PTR_W'(1);
	assign rd_ptr_nx = (rd_ptr_q == '0) ? PTR_W'(MAX_TAPS - 1) : rd_ptr_q - PTR_W'(1);
	assign issue     = (state_q == ST_RUN) && (j_q < n_q);
	assign out_free  = !out_valid_q || m_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);

	// Memories: tap store and delay line samples, with registered reads.
	logic signed [SAMPLE_BITS-1:0] tap_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] dl_mem  [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] tap_rd_s1;
	logic signed [SAMPLE_BITS-1:0] dl_rd_s1;
	logic                          dlv_s1;
	logic                          tap_we;
	logic                          dl_we;

	assign tap_we = in_acc && (in_mode == linconv_pkg::MODE_LOAD_TAP)
	                && (int'(in_idx) < MAX_TAPS);
	assign dl_we  = in_acc && (in_mode == linconv_pkg::MODE_SAMPLE);

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[PTR_W'(in_idx)] <= in_val;
		end
		if (dl_we) begin
			dl_mem[head_nx] <= in_val;
		end
		tap_rd_s1 <= tap_mem[j_q[PTR_W-1:0]];
		dl_rd_s1  <= dl_mem[rd_ptr_q];
		dlv_s1    <= dl_valid_q[rd_ptr_q];
	end

	// A new sum starts on an accepted sample or on each tail step.
	assign mac_ctl = '{clr: dl_we || (state_q == ST_STEP), en: v_s1};

	linconv_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.tap    (tap_rd_s1),
		.smp    (dlv_s1 ? dl_rd_s1 : '0),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			rd_ptr_q    <= '0;
			dl_valid_q  <= '0;
			n_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			tail_q      <= 1'b0;
			last_q      <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
		end else begin
			v_s1 <= issue;
			// In ST_FIN the output register is reloaded below instead.
			if (out_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_mode)
							linconv_pkg::MODE_SAMPLE: begin
								head_q              <= head_nx;
								rd_ptr_q            <= head_nx;
								dl_valid_q[head_nx] <= 1'b1;
								n_q                 <= n_act;
								j_q                 <= '0;
								tail_q              <= 1'b0;
								last_q              <= 1'b1;
								state_q             <= ST_RUN;
							end
							linconv_pkg::MODE_FLUSH: begin
								n_q <= n_act;
								k_q <= '0;
								if (n_act == CNT_W'(1)) begin
									// One tap: no tail, only the delay line is emptied.
									dl_valid_q <= '0;
								end else begin
									state_q <= ST_STEP;
								end
							end
							default: begin
								// Tap loads are written above; unused kinds are dropped.
							end
						endcase
					end
				end
				ST_STEP: begin
					head_q              <= head_nx;
					rd_ptr_q            <= head_nx;
					dl_valid_q[head_nx] <= 1'b0;
					j_q                 <= '0;
					tail_q              <= 1'b1;
					last_q              <= (int'(k_q) + 2 == int'(n_q));
					state_q             <= ST_RUN;
				end
				ST_RUN: begin
					if (issue) begin
						j_q      <= j_q + CNT_W'(1);
						rd_ptr_q <= rd_ptr_nx;
					end else if (!v_s1 && !mac_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= mac_acc;
						out_last_q  <= last_q;
						if (!tail_q) begin
							state_q <= ST_IDLE;
						end else if (last_q) begin
							dl_valid_q <= '0;
							state_q    <= ST_IDLE;
						end else begin
							k_q     <= k_q + CNT_W'(1);
							state_q <= ST_STEP;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{(linconv_pkg::OUT_TDATA_W - linconv_pkg::RES_W){1'b0}}, out_data_q};

endmodule
